// ===== hw/rtl/mrlps_pkg.sv =====
// ---------------------------------------------------------------------------
// mrlps_pkg
// Shared types and constants of the multi-radio link preference selector.
// ---------------------------------------------------------------------------
package mrlps_pkg;

    // Default neighbor table size
    localparam int NEIGHBOR_COUNT_DEF = 32;
    // Two links per neighbor: overlay, then 802.15.4
    localparam int RADIO_COUNT = 2;
    // Neighbor index field width fixes the addressable entries
    localparam int NB_W = 5;
    localparam int NB_SPAN = 1 << NB_W;
    localparam int PREF_W = 8;
    localparam int DELTA_W = 9;

    // Operation codes
    localparam logic [1:0] OP_RECEIVE   = 2'd0;
    localparam logic [1:0] OP_SEND_DONE = 2'd1;
    localparam logic [1:0] OP_LATE_ACK  = 2'd2;
    localparam logic [1:0] OP_SELECT    = 2'd3;

    // Link codes
    localparam logic LINK_OVERLAY = 1'b0;
    localparam logic LINK_15_4    = 1'b1;

    // Register map, index = byte address / 4
    localparam int APB_ADDR_W = 5;
    localparam logic [2:0] REG_HIGH_THRESHOLD   = 3'd0;
    localparam logic [2:0] REG_INITIAL_PREF     = 3'd1;
    localparam logic [2:0] REG_DELTA_RX         = 3'd2;
    localparam logic [2:0] REG_DELTA_RX_DUP     = 3'd3;
    localparam logic [2:0] REG_DELTA_TX_OK      = 3'd4;
    localparam logic [2:0] REG_DELTA_TX_ERR     = 3'd5;
    localparam logic [2:0] REG_DELTA_ACK_OK     = 3'd6;
    localparam logic [2:0] REG_DELTA_ACK_TMO    = 3'd7;

    // Register reset values
    localparam logic [PREF_W-1:0]  RST_HIGH_THRESHOLD = 8'd220;
    localparam logic [PREF_W-1:0]  RST_INITIAL_PREF   = 8'd200;
    localparam logic [DELTA_W-1:0] RST_DELTA_RX       = 9'd15;
    localparam logic [DELTA_W-1:0] RST_DELTA_RX_DUP   = 9'd15;
    localparam logic [DELTA_W-1:0] RST_DELTA_TX_OK    = 9'd25;
    localparam logic [DELTA_W-1:0] RST_DELTA_TX_ERR   = 9'h1D8;  // -40
    localparam logic [DELTA_W-1:0] RST_DELTA_ACK_OK   = 9'd25;
    localparam logic [DELTA_W-1:0] RST_DELTA_ACK_TMO  = 9'h19C;  // -100

    // Input item
    typedef struct packed {
        logic [1:0]      operation;
        logic [NB_W-1:0] neighbor_index;
        logic            radio_type;
        logic            is_duplicate;
        logic            tx_ok;
        logic            ack_requested;
        logic            neighbor_found;
        logic            dest_broadcast;
        logic            preset_valid;
        logic            probe_chance;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0] tx_mask;
        logic [1:0] required_mask;
        logic       selected_radio;
        logic       allow_remove;
        logic       crossed_threshold;
        logic       radio_added;
    } t_out_item;

    // One neighbor row of the link table
    typedef struct packed {
        logic [RADIO_COUNT-1:0]             sup;
        logic [RADIO_COUNT-1:0][PREF_W-1:0] pref;
    } t_entry;

endpackage

// ===== hw/rtl/mrlps_ram.sv =====
// ---------------------------------------------------------------------------
// mrlps_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mrlps_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/multi_radio_link_preference_selector.sv =====
// ---------------------------------------------------------------------------
// multi_radio_link_preference_selector
// Per-neighbor link table (supported bits and preferences for the overlay
// and 802.15.4 links), updated by link events and read for send selection.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  in        input      i_in_valid / o_in_stall      i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_stall    o_out_data (t_out_item)
//  config    input      APB psel/penable/pready      paddr, pwdata, prdata
//
//  Each item is accepted in S_IDLE, where the neighbor row is read from the link
//  table RAM at the accept edge, and is written back with the result in S_EXEC.
//  The RAM's registered read sets this order; one item is in flight.
//  Reset clears the per-row valid flags at once, no clearing pass is needed.
//  A stalled output holds the row write-back until the output register frees.
//  A new item is taken while an earlier result still waits at the output.
// ---------------------------------------------------------------------------
module multi_radio_link_preference_selector #(
    parameter int NEIGHBOR_COUNT = mrlps_pkg::NEIGHBOR_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  mrlps_pkg::t_in_item                 i_in_data,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output mrlps_pkg::t_out_item                o_out_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mrlps_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import mrlps_pkg::*;

    // Only the rows reachable by the index field are stored
    localparam int ENTRY_COUNT = (NEIGHBOR_COUNT < NB_SPAN) ? NEIGHBOR_COUNT : NB_SPAN;
    localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int VALID_COUNT = 1 << ADDR_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // Configuration registers
    logic [PREF_W-1:0]  r_high_threshold;
    logic [PREF_W-1:0]  r_initial_pref;
    logic [DELTA_W-1:0] r_delta_rx;
    logic [DELTA_W-1:0] r_delta_rx_dup;
    logic [DELTA_W-1:0] r_delta_tx_ok;
    logic [DELTA_W-1:0] r_delta_tx_err;
    logic [DELTA_W-1:0] r_delta_ack_ok;
    logic [DELTA_W-1:0] r_delta_ack_tmo;

    logic [2:0] cfg_idx;
    logic       cfg_write;

    // Sequencer and item registers
    logic                   r_state;
    logic                   n_state;
    t_in_item               r_item;
    logic                   r_nb_ok;
    logic                   r_hit;
    logic [VALID_COUNT-1:0] r_entry_valid;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    logic              in_accept;
    logic              nb_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              out_free;
    logic              exec_fire;
    logic              row_we;
    t_entry            rd_entry;
    t_entry            n_entry;
    t_out_item         n_out;

    // ---------------------------------------------------------------
    // APB register port
    // ---------------------------------------------------------------
    assign cfg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_threshold <= RST_HIGH_THRESHOLD;
            r_initial_pref   <= RST_INITIAL_PREF;
            r_delta_rx       <= RST_DELTA_RX;
            r_delta_rx_dup   <= RST_DELTA_RX_DUP;
            r_delta_tx_ok    <= RST_DELTA_TX_OK;
            r_delta_tx_err   <= RST_DELTA_TX_ERR;
            r_delta_ack_ok   <= RST_DELTA_ACK_OK;
            r_delta_ack_tmo  <= RST_DELTA_ACK_TMO;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_HIGH_THRESHOLD: r_high_threshold <= pwdata[PREF_W-1:0];
                REG_INITIAL_PREF:   r_initial_pref   <= pwdata[PREF_W-1:0];
                REG_DELTA_RX:       r_delta_rx       <= pwdata[DELTA_W-1:0];
                REG_DELTA_RX_DUP:   r_delta_rx_dup   <= pwdata[DELTA_W-1:0];
                REG_DELTA_TX_OK:    r_delta_tx_ok    <= pwdata[DELTA_W-1:0];
                REG_DELTA_TX_ERR:   r_delta_tx_err   <= pwdata[DELTA_W-1:0];
                REG_DELTA_ACK_OK:   r_delta_ack_ok   <= pwdata[DELTA_W-1:0];
                REG_DELTA_ACK_TMO:  r_delta_ack_tmo  <= pwdata[DELTA_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        prdata = 32'd0;
        case (cfg_idx)
            REG_HIGH_THRESHOLD: prdata = {24'd0, r_high_threshold};
            REG_INITIAL_PREF:   prdata = {24'd0, r_initial_pref};
            REG_DELTA_RX:       prdata = {23'd0, r_delta_rx};
            REG_DELTA_RX_DUP:   prdata = {23'd0, r_delta_rx_dup};
            REG_DELTA_TX_OK:    prdata = {23'd0, r_delta_tx_ok};
            REG_DELTA_TX_ERR:   prdata = {23'd0, r_delta_tx_err};
            REG_DELTA_ACK_OK:   prdata = {23'd0, r_delta_ack_ok};
            REG_DELTA_ACK_TMO:  prdata = {23'd0, r_delta_ack_tmo};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshakes and sequencing
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign nb_ok      = (32'(i_in_data.neighbor_index) < NEIGHBOR_COUNT);
    assign rd_addr    = i_in_data.neighbor_index[ADDR_W-1:0];
    assign wr_addr    = r_item.neighbor_index[ADDR_W-1:0];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign exec_fire  = (r_state == S_EXEC) && out_free;
    assign row_we     = exec_fire && r_nb_ok && (r_item.operation != OP_SELECT);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_accept) n_state = S_EXEC;
            S_EXEC:  if (out_free)  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_valid <= '0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // a written row is known from then on
            if (row_we) begin
                r_entry_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Item capture at accept, result capture when the item executes
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item  <= i_in_data;
            r_nb_ok <= nb_ok;
            r_hit   <= r_entry_valid[rd_addr];
        end
        if (exec_fire) begin
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------------------------------------------------------
    // Link table
    // ---------------------------------------------------------------
    mrlps_ram #(
        .WIDTH  ($bits(t_entry)),
        .DEPTH  (ENTRY_COUNT),
        .ADDR_W (ADDR_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (wr_addr),
        .i_wdata (n_entry),
        .i_re    (in_accept),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    // ---------------------------------------------------------------
    // Row update and result
    // ---------------------------------------------------------------
    always_comb begin
        logic [RADIO_COUNT-1:0] sup;
        logic                   link;
        logic                   has_t;
        logic                   do_delta;
        logic                   do_add;
        logic                   skip;
        logic [DELTA_W-1:0]     delta;
        logic [PREF_W-1:0]      old_pref;
        logic [PREF_W+1:0]      sum;
        logic [PREF_W-1:0]      clamped;
        logic                   good0;
        logic                   good1;
        logic                   sel;

        sup      = r_hit ? rd_entry.sup : '0;
        link     = (r_item.operation == OP_LATE_ACK) ? LINK_OVERLAY : r_item.radio_type;
        has_t    = sup[link];
        do_delta = 1'b0;
        do_add   = 1'b0;
        delta    = r_delta_rx;
        skip     = 1'b0;
        n_out    = '0;
        sel      = LINK_OVERLAY;

        // which update this event asks for
        case (r_item.operation)
            OP_RECEIVE: begin
                delta    = r_item.is_duplicate ? r_delta_rx_dup : r_delta_rx;
                do_delta = r_nb_ok && has_t;
                do_add   = r_nb_ok && !has_t;
            end
            OP_SEND_DONE: begin
                skip = ((link == LINK_OVERLAY) && r_item.tx_ok) || !r_item.ack_requested
                       || !r_item.neighbor_found || !r_nb_ok;
                delta    = r_item.tx_ok ? r_delta_tx_ok : r_delta_tx_err;
                do_delta = !skip && has_t;
                do_add   = !skip && !has_t && r_item.tx_ok;
            end
            OP_LATE_ACK: begin
                delta    = r_item.tx_ok ? r_delta_ack_ok : r_delta_ack_tmo;
                do_delta = r_nb_ok && has_t;
                do_add   = r_nb_ok && !has_t && r_item.tx_ok;
            end
            default: ;
        endcase

        // clamped add of the signed delta
        old_pref = rd_entry.pref[link];
        sum      = {2'b00, old_pref} + {delta[DELTA_W-1], delta};
        if (sum[PREF_W+1]) begin
            clamped = '0;
        end else if (sum[PREF_W]) begin
            clamped = '1;
        end else begin
            clamped = sum[PREF_W-1:0];
        end

        // row write-back
        n_entry     = rd_entry;
        n_entry.sup = sup;
        if (do_delta) begin
            n_entry.pref[link] = clamped;
        end
        if (do_add) begin
            n_entry.sup[link]  = 1'b1;
            n_entry.pref[link] = r_initial_pref;
        end

        // send selection: first good link, else highest preference
        good0 = sup[LINK_OVERLAY] && (rd_entry.pref[LINK_OVERLAY] >= r_high_threshold);
        good1 = sup[LINK_15_4] && (rd_entry.pref[LINK_15_4] >= r_high_threshold);
        if (!good0 && sup[LINK_15_4] && (good1 || !sup[LINK_OVERLAY]
                || (rd_entry.pref[LINK_OVERLAY] < rd_entry.pref[LINK_15_4]))) begin
            sel = LINK_15_4;
        end

        case (r_item.operation)
            OP_SELECT: begin
                if (r_item.dest_broadcast) begin
                    n_out.tx_mask = 2'b11;
                end else if (r_item.preset_valid) begin
                    n_out.selected_radio = r_item.radio_type;
                    n_out.tx_mask        = r_item.radio_type ? 2'b10 : 2'b01;
                end else if (!r_item.neighbor_found || !r_nb_ok || (sup == '0)) begin
                    n_out.tx_mask = 2'b11;
                end else begin
                    n_out.selected_radio = sel;
                    n_out.tx_mask        = sel ? 2'b10 : 2'b01;
                    // probe the overlay link alongside 802.15.4
                    if ((sel == LINK_15_4) && sup[LINK_OVERLAY] && r_item.probe_chance) begin
                        n_out.required_mask = 2'b10;
                        n_out.tx_mask       = 2'b11;
                    end
                end
            end
            default: begin
                n_out.crossed_threshold = do_delta
                    && ((old_pref >= r_high_threshold) != (clamped >= r_high_threshold));
                n_out.radio_added = do_add;
                if (r_item.operation == OP_LATE_ACK) begin
                    // a good 802.15.4 link keeps the neighbor after an overlay timeout
                    n_out.allow_remove = !(do_delta && !r_item.tx_ok && good1);
                end
            end
        endcase
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-radio link preference selector. A
// scoreboard class mirrors the per-neighbor link table and the registers,
// works out each link decision as an event transfer is accepted, and checks
// every result transfer field by field. A directed opening runs at reset
// settings. It is followed by eight register settings, extremes among them,
// each with a burst of random events aimed at a small group of neighbors.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrlps_pkg::*;

    // Event flag bits, in item order after radio_type
    localparam logic [6:0] F_DUP    = 7'b1000000;
    localparam logic [6:0] F_OK     = 7'b0100000;
    localparam logic [6:0] F_ACK    = 7'b0010000;
    localparam logic [6:0] F_FOUND  = 7'b0001000;
    localparam logic [6:0] F_BCAST  = 7'b0000100;
    localparam logic [6:0] F_PRESET = 7'b0000010;
    localparam logic [6:0] F_PROBE  = 7'b0000001;

    localparam logic [DELTA_W-1:0] DELTA_MIN = 9'h101;  // -255
    localparam logic [DELTA_W-1:0] DELTA_MAX = 9'h0FF;  // +255
    localparam int PHASES           = 8;
    localparam int EVENTS_PER_PHASE = 100;
    localparam int HOLD_CYCLES      = 200;
    localparam int BURST_EVENTS     = 40;
    localparam int IN_W             = $bits(t_in_item);

    // -----------------------------------------------------------------------
    // Link table mirror and expected decisions
    // -----------------------------------------------------------------------
    class link_pref_scoreboard;
        logic [PREF_W-1:0]         thr;
        logic [PREF_W-1:0]         init_pref;
        logic signed [DELTA_W-1:0] d_rx, d_rx_dup, d_tx_ok, d_tx_err, d_ack_ok, d_ack_tmo;
        logic [RADIO_COUNT-1:0]    sup [NB_SPAN];
        logic [PREF_W-1:0]         pref [NB_SPAN][RADIO_COUNT];
        t_out_item                 pending_decisions [$];
        int unsigned               errors;

        function new();
            thr       = RST_HIGH_THRESHOLD;
            init_pref = RST_INITIAL_PREF;
            d_rx      = RST_DELTA_RX;
            d_rx_dup  = RST_DELTA_RX_DUP;
            d_tx_ok   = RST_DELTA_TX_OK;
            d_tx_err  = RST_DELTA_TX_ERR;
            d_ack_ok  = RST_DELTA_ACK_OK;
            d_ack_tmo = RST_DELTA_ACK_TMO;
            foreach (sup[i]) sup[i] = '0;
            foreach (pref[i, j]) pref[i][j] = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DELTA_W-1:0] v);
            case (idx)
                REG_HIGH_THRESHOLD: thr       = v[PREF_W-1:0];
                REG_INITIAL_PREF:   init_pref = v[PREF_W-1:0];
                REG_DELTA_RX:       d_rx      = v;
                REG_DELTA_RX_DUP:   d_rx_dup  = v;
                REG_DELTA_TX_OK:    d_tx_ok   = v;
                REG_DELTA_TX_ERR:   d_tx_err  = v;
                REG_DELTA_ACK_OK:   d_ack_ok  = v;
                REG_DELTA_ACK_TMO:  d_ack_tmo = v;
                default: ;
            endcase
        endfunction

        // Clamped update, returns the threshold crossing flag
        function logic bump(int nb, int lk, logic signed [DELTA_W-1:0] delta);
            int old_p;
            int new_p;
            old_p = int'(pref[nb][lk]);
            new_p = old_p + int'(delta);
            if (new_p > 255) new_p = 255;
            if (new_p < 0) new_p = 0;
            pref[nb][lk] = PREF_W'(new_p);
            return (old_p >= int'(thr)) != (new_p >= int'(thr));
        endfunction

        function void mark(int nb, int lk);
            sup[nb][lk]  = 1'b1;
            pref[nb][lk] = init_pref;
        endfunction

        // Apply one accepted event and queue the decision it yields
        function void note_event(t_in_item it);
            t_out_item r;
            int        nb;
            int        lk;
            int        sel;
            int        best;
            bit        have;
            r  = '0;
            nb = int'(it.neighbor_index);
            lk = int'(it.radio_type);
            case (it.operation)
                OP_RECEIVE: begin
                    if (sup[nb][lk]) begin
                        r.crossed_threshold = bump(nb, lk, it.is_duplicate ? d_rx_dup : d_rx);
                    end else begin
                        mark(nb, lk);
                        r.radio_added = 1'b1;
                    end
                end
                OP_SEND_DONE: begin
                    // overlay success waits for its deferred ack
                    if (it.ack_requested && it.neighbor_found &&
                            !(it.radio_type == LINK_OVERLAY && it.tx_ok)) begin
                        if (sup[nb][lk]) begin
                            r.crossed_threshold = bump(nb, lk, it.tx_ok ? d_tx_ok : d_tx_err);
                        end else if (it.tx_ok) begin
                            mark(nb, lk);
                            r.radio_added = 1'b1;
                        end
                    end
                end
                OP_LATE_ACK: begin
                    r.allow_remove = 1'b1;
                    if (sup[nb][LINK_OVERLAY]) begin
                        r.crossed_threshold = bump(nb, int'(LINK_OVERLAY),
                                                   it.tx_ok ? d_ack_ok : d_ack_tmo);
                        // a good 802.15.4 link keeps the neighbor alive
                        if (!it.tx_ok && sup[nb][LINK_15_4] && pref[nb][LINK_15_4] >= thr) begin
                            r.allow_remove = 1'b0;
                        end
                    end else if (it.tx_ok) begin
                        mark(nb, int'(LINK_OVERLAY));
                        r.radio_added = 1'b1;
                    end
                end
                OP_SELECT: begin
                    if (it.dest_broadcast) begin
                        r.tx_mask = 2'b11;
                    end else if (it.preset_valid) begin
                        r.selected_radio = it.radio_type;
                        r.tx_mask        = 2'b01 << lk;
                    end else if (!it.neighbor_found || sup[nb] == '0) begin
                        r.tx_mask = 2'b11;
                    end else begin
                        // first good link wins, else the highest preference
                        sel  = int'(LINK_OVERLAY);
                        have = 1'b0;
                        best = 0;
                        for (int k = 0; k < RADIO_COUNT; k++) begin
                            if (sup[nb][k]) begin
                                if (pref[nb][k] >= thr) begin
                                    sel = k;
                                    break;
                                end
                                if (!have || best < int'(pref[nb][k])) begin
                                    have = 1'b1;
                                    sel  = k;
                                    best = int'(pref[nb][k]);
                                end
                            end
                        end
                        r.selected_radio = sel[0];
                        r.tx_mask        = 2'b01 << sel;
                        if (sel != int'(LINK_OVERLAY) && sup[nb][LINK_OVERLAY]
                                && it.probe_chance) begin
                            r.required_mask = r.tx_mask;
                            r.tx_mask       = r.tx_mask | 2'b01;
                        end
                    end
                end
                default: ;
            endcase
            pending_decisions.push_back(r);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_decision(t_out_item got);
            t_out_item want;
            if (pending_decisions.size() == 0) begin
                $display("%0t ns: result %h with nothing expected", $time, got);
                errors++;
                return;
            end
            want = pending_decisions.pop_front();
            field_check("tx_mask", 32'(want.tx_mask), 32'(got.tx_mask));
            field_check("required_mask", 32'(want.required_mask), 32'(got.required_mask));
            field_check("selected_radio", 32'(want.selected_radio), 32'(got.selected_radio));
            field_check("allow_remove", 32'(want.allow_remove), 32'(got.allow_remove));
            field_check("crossed_threshold", 32'(want.crossed_threshold),
                        32'(got.crossed_threshold));
            field_check("radio_added", 32'(want.radio_added), 32'(got.radio_added));
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Signals and block
    // -----------------------------------------------------------------------
    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    link_pref_scoreboard sb;

    multi_radio_link_preference_selector dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Drivers, all entered and left at a falling edge
    // -----------------------------------------------------------------------
    task automatic apb_xfer(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Write a register, mirror it, and read it back
    task automatic write_reg(input logic [2:0] idx, input logic [DELTA_W-1:0] v);
        logic [31:0]        rd;
        logic [DELTA_W-1:0] mask;
        logic [DELTA_W-1:0] val;
        mask = (idx == REG_HIGH_THRESHOLD || idx == REG_INITIAL_PREF) ? 9'h0FF : 9'h1FF;
        val  = v & mask;
        apb_xfer(idx, 1'b1, {{(32-DELTA_W){val[DELTA_W-1]}}, val}, rd);
        sb.set_reg(idx, val);
        apb_xfer(idx, 1'b0, '0, rd);
        if ((rd[DELTA_W-1:0] & mask) != val) begin
            $display("%0t ns: register %0d readback, expected %h, actual %h",
                     $time, idx, val, rd[DELTA_W-1:0] & mask);
            sb.errors++;
        end
    endtask

    task automatic push_event(input t_in_item it, input int unsigned gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        sb.note_event(it);
        @(negedge clk);
    endtask

    // Stop offering events and wait out every pending decision
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_decisions.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic int unsigned tx_gap();
        return tx_idle_on ? $urandom_range(0, 19) : 0;
    endfunction

    function automatic t_in_item ev(input logic [1:0] op, input logic [NB_W-1:0] nb,
                                    input logic lk, input logic [6:0] flags);
        return {op, nb, lk, flags};
    endfunction

    function automatic logic [DELTA_W-1:0] rand_delta();
        int d;
        if ($urandom_range(0, 7) == 0) begin
            d = $urandom_range(0, 1) ? 255 : -255;
        end else begin
            d = int'($urandom_range(0, 120)) - 60;
        end
        return DELTA_W'(d);
    endfunction

    // Random event, mostly aimed at a small neighbor group so links build up
    function automatic t_in_item draw_event(input logic [NB_W-1:0] pool_base);
        t_in_item        it;
        logic [IN_W-1:0] raw;
        raw = IN_W'($urandom);
        it  = raw;
        if ($urandom_range(0, 9) < 7) begin
            it.neighbor_index = pool_base + NB_W'($urandom_range(0, 3));
        end
        case (it.operation)
            OP_SEND_DONE: begin
                if ($urandom_range(0, 4) != 0) begin
                    it.ack_requested  = 1'b1;
                    it.neighbor_found = 1'b1;
                end
            end
            OP_SELECT: begin
                it.dest_broadcast = ($urandom_range(0, 6) == 0);
                it.preset_valid   = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 7) != 0) it.neighbor_found = 1'b1;
            end
            default: ;
        endcase
        return it;
    endfunction

    // -----------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // -----------------------------------------------------------------------
    initial begin
        int unsigned w;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                w = rx_idle_on ? $urandom_range(0, 19) : 0;
                if (w > 0) begin
                    out_stall <= 1'b1;
                    repeat (w) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_decision(out_data);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        t_in_item           directed_events [$];
        logic [DELTA_W-1:0] cfg_vals [8];
        logic [NB_W-1:0]    pool_base;
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening at reset settings
        directed_events.push_back(ev(OP_SELECT, 0, LINK_OVERLAY, F_FOUND));    // no links yet
        directed_events.push_back(ev(OP_RECEIVE, 0, LINK_OVERLAY, '0));        // new link
        directed_events.push_back(ev(OP_RECEIVE, 0, LINK_OVERLAY, F_DUP));
        directed_events.push_back(ev(OP_RECEIVE, 0, LINK_OVERLAY, '0));        // goes over
        directed_events.push_back(ev(OP_SEND_DONE, 0, LINK_OVERLAY, F_OK | F_ACK | F_FOUND));
        directed_events.push_back(ev(OP_SEND_DONE, 0, LINK_15_4, F_ACK | F_FOUND));
        directed_events.push_back(ev(OP_SEND_DONE, 0, LINK_15_4, F_OK | F_ACK | F_FOUND));
        directed_events.push_back(ev(OP_SEND_DONE, 0, LINK_15_4, F_OK | F_FOUND));  // no ack
        directed_events.push_back(ev(OP_SEND_DONE, 0, LINK_15_4, F_OK | F_ACK));    // no nbr
        directed_events.push_back(ev(OP_SEND_DONE, 0, LINK_15_4, F_OK | F_ACK | F_FOUND));
        directed_events.push_back(ev(OP_SELECT, 0, LINK_OVERLAY, F_FOUND | F_PROBE));
        directed_events.push_back(ev(OP_LATE_ACK, 0, LINK_OVERLAY, '0));       // kept alive
        directed_events.push_back(ev(OP_SELECT, 0, LINK_OVERLAY, F_FOUND | F_PROBE));
        directed_events.push_back(ev(OP_SELECT, 0, LINK_OVERLAY, F_FOUND));
        directed_events.push_back(ev(OP_SELECT, 0, LINK_15_4, F_FOUND | F_BCAST));
        directed_events.push_back(ev(OP_SELECT, 31, LINK_15_4, F_PRESET | F_PROBE));
        directed_events.push_back(ev(OP_SELECT, 31, LINK_OVERLAY, F_PRESET | F_FOUND));
        directed_events.push_back(ev(OP_SELECT, 0, LINK_OVERLAY, F_PROBE));    // not found
        directed_events.push_back(ev(OP_LATE_ACK, 31, LINK_OVERLAY, F_FOUND)); // unknown link
        directed_events.push_back(ev(OP_LATE_ACK, 31, LINK_15_4, F_OK));
        directed_events.push_back(ev(OP_SEND_DONE, 31, LINK_OVERLAY, F_ACK | F_FOUND));
        directed_events.push_back(ev(OP_RECEIVE, 31, LINK_15_4, F_DUP));
        directed_events.push_back(ev(OP_SELECT, 31, LINK_OVERLAY, F_FOUND | F_PROBE));
        directed_events.push_back(ev(OP_LATE_ACK, 0, LINK_OVERLAY, F_OK));
        directed_events.push_back(ev(OP_SELECT, 31, LINK_15_4, 7'h7F));
        foreach (directed_events[i]) push_event(directed_events[i], tx_gap());

        // Random phases, each under its own register setting
        for (int p = 1; p <= PHASES; p++) begin
            drain();
            for (int r = REG_DELTA_RX; r <= REG_DELTA_ACK_TMO; r++) begin
                cfg_vals[r] = (p == 1) ? DELTA_MIN : (p == 2) ? DELTA_MAX : rand_delta();
            end
            case (p)
                1: begin
                    cfg_vals[REG_HIGH_THRESHOLD] = 9'd0;
                    cfg_vals[REG_INITIAL_PREF]   = 9'd255;
                end
                2: begin
                    cfg_vals[REG_HIGH_THRESHOLD] = 9'd255;
                    cfg_vals[REG_INITIAL_PREF]   = 9'd0;
                end
                default: begin
                    cfg_vals[REG_HIGH_THRESHOLD] = DELTA_W'($urandom_range(0, 255));
                    cfg_vals[REG_INITIAL_PREF]   = DELTA_W'($urandom_range(0, 255));
                end
            endcase
            for (int r = 0; r < 8; r++) write_reg(3'(r), cfg_vals[r]);

            tx_idle_on = (p != 2) && (p != 5);
            rx_idle_on = (p != 2) && (p != 6);
            pool_base  = NB_W'($urandom_range(0, NB_SPAN - 1));
            // one phase backs the block up behind a long output hold-off
            if (p == 3) hold_req = 1'b1;
            for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
                push_event(draw_event(pool_base),
                           (p == 3 && n < BURST_EVENTS) ? 0 : tx_gap());
            end
        end

        drain();
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending_decisions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/mrlps_pkg.sv
hw/rtl/mrlps_ram.sv
hw/rtl/multi_radio_link_preference_selector.sv
tb/sv/tb_top.sv
